// ===== rtl/core/steq_pkg.sv =====
`timescale 1ns / 1ps

package steq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int TIME_W    = 48;
	localparam int ID_W      = 16;
	localparam int OCC_W     = 5;

	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_TICK = 2'd1,
		CMD_STOP = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		K_ADDED    = 3'd0,
		K_REF_STOP = 3'd1,
		K_REF_FULL = 3'd2,
		K_FIRED    = 3'd3,
		K_NONE_DUE = 3'd4,
		K_STOPPED  = 3'd5
	} kind_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ID_W-1:0]   event_id;
		logic [TIME_W-1:0] due_time;
		logic [TIME_W-1:0] now_time;
	} cmd_item_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   fired_id;
		logic [TIME_W-1:0] fired_due;
		logic              last;
		logic              accepting;
		logic [OCC_W-1:0]  occupancy;
	} res_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [ID_W-1:0]   id;
	} entry_t;

endpackage

// ===== rtl/core/sorted_timer_event_queue.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// cmd      in         cmd_valid / cmd_ready  cmd_item (steq_pkg::cmd_item_t)
// res      out        res_valid / res_ready  res_item (steq_pkg::res_item_t)
//
// Entries sit in a circular buffer in one synchronous RAM (one read, one write port).
// Add: S_ADD_RD and S_ADD_CMP shift each entry later than the new one up one slot, then
// write the new entry. Tick: S_TICK_RD, then S_TICK_CMP fires due entries from the head.
// Ticks when empty or stopped, stops and refusals go straight from idle to S_EMIT.
// Reset clears the count, head pointer and stop flag; RAM contents are not cleared.
// A full result register stalls the tick walk and the emit step; cmd_ready only in idle.

module sorted_timer_event_queue #(
	parameter int QUEUE_DEPTH = steq_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  steq_pkg::cmd_item_t cmd_item,
	output logic                res_valid,
	input  logic                res_ready,
	output steq_pkg::res_item_t res_item
);
	import steq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_CMP,
		S_TICK_RD,
		S_TICK_CMP,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic              accept_q;
	kind_t             kind_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] due_q;
	logic [TIME_W-1:0] now_q;
	entry_t            pend_q;
	logic              pend_valid_q;
	logic              res_valid_q;
	res_item_t         res_q;

	entry_t            mem_q [QUEUE_DEPTH];
	entry_t            rd_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	entry_t            mem_wdata;
	logic [AW-1:0]     rd_addr;
	logic [CW-1:0]     rd_off;
	logic              res_free;
	logic              due_now;
	logic              advance;
	logic              shift;
	logic              res_load;

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(QUEUE_DEPTH))
			s = s - (CW+1)'(QUEUE_DEPTH);
		return s[AW-1:0];
	endfunction

	assign res_free  = !res_valid_q || res_ready;
	assign due_now   = rd_q.due <= now_q;
	assign advance   = due_now && !(pend_valid_q && !res_free);
	assign shift     = rd_q.due > due_q;
	assign res_load  = (state_q == S_TICK_CMP && advance && pend_valid_q) ||
		(state_q == S_EMIT && res_free);
	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	always_comb begin
		rd_off    = '0;
		mem_we    = 1'b0;
		mem_waddr = wrap(head_q, idx_q);
		mem_wdata = '{due: due_q, id: id_q};
		case (state_q)
			S_ADD_RD: begin
				rd_off = (idx_q != '0) ? idx_q - CW'(1) : '0;
				mem_we = (idx_q == '0);
			end
			S_ADD_CMP: begin
				rd_off = (idx_q > CW'(1)) ? idx_q - CW'(2) : '0;
				mem_we = 1'b1;
				if (shift)
					mem_wdata = rd_q;
			end
			S_TICK_CMP: begin
				rd_off = advance ? CW'(1) : '0;
			end
			default: begin
				rd_off = '0;
			end
		endcase
		rd_addr = wrap(head_q, rd_off);
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			accept_q     <= 1'b1;
			kind_q       <= K_ADDED;
			id_q         <= '0;
			due_q        <= '0;
			now_q        <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						id_q  <= cmd_item.event_id;
						due_q <= cmd_item.due_time;
						now_q <= cmd_item.now_time;
						case (cmd_item.cmd)
							CMD_ADD: begin
								if (!accept_q) begin
									kind_q  <= K_REF_STOP;
									state_q <= S_EMIT;
								end else if (count_q == CW'(QUEUE_DEPTH)) begin
									kind_q  <= K_REF_FULL;
									state_q <= S_EMIT;
								end else begin
									idx_q   <= count_q;
									state_q <= S_ADD_RD;
								end
							end
							CMD_TICK: begin
								if (!accept_q || count_q == '0) begin
									kind_q  <= K_NONE_DUE;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_TICK_RD;
								end
							end
							CMD_STOP: begin
								accept_q <= 1'b0;
								kind_q   <= K_STOPPED;
								state_q  <= S_EMIT;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ADD_RD: begin
					if (idx_q == '0) begin
						count_q <= count_q + CW'(1);
						kind_q  <= K_ADDED;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_ADD_CMP;
					end
				end
				S_ADD_CMP: begin
					if (shift) begin
						idx_q <= idx_q - CW'(1);
						if (idx_q == CW'(1))
							state_q <= S_ADD_RD;
					end else begin
						count_q <= count_q + CW'(1);
						kind_q  <= K_ADDED;
						state_q <= S_EMIT;
					end
				end
				S_TICK_RD: begin
					state_q <= S_TICK_CMP;
				end
				S_TICK_CMP: begin
					if (due_now) begin
						if (advance) begin
							if (pend_valid_q) begin
								res_q <= '{kind: K_FIRED, fired_id: pend_q.id,
									fired_due: pend_q.due, last: 1'b0, accepting: accept_q,
									occupancy: OCC_W'(count_q)};
							end
							pend_q       <= rd_q;
							pend_valid_q <= 1'b1;
							head_q       <= wrap(head_q, CW'(1));
							count_q      <= count_q - CW'(1);
							if (count_q == CW'(1)) begin
								kind_q  <= K_FIRED;
								state_q <= S_EMIT;
							end
						end
					end else begin
						kind_q  <= pend_valid_q ? K_FIRED : K_NONE_DUE;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (res_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
						if (kind_q == K_FIRED)
							res_q <= '{kind: K_FIRED, fired_id: pend_q.id,
								fired_due: pend_q.due, last: 1'b1, accepting: accept_q,
								occupancy: OCC_W'(count_q)};
						else
							res_q <= '{kind: kind_q, fired_id: '0, fired_due: '0,
								last: 1'b1, accepting: accept_q,
								occupancy: OCC_W'(count_q)};
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above depth");

	a_stop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!accept_q |=> !accept_q)
		else $error("accept flag returned after stop");

	a_write_in_add: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_ADD_RD || state_q == S_ADD_CMP))
		else $error("RAM write outside add");

	a_pend_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q == S_TICK_CMP || state_q == S_EMIT))
		else $error("held fired item outside tick");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK_CMP && advance) |=> count_q == $past(count_q) - CW'(1))
		else $error("fire did not remove one entry");
`endif

endmodule

// ===== tb/sorted_timer_event_queue_tb.sv =====
`timescale 1ns / 1ps

module sorted_timer_event_queue_tb;
	import steq_pkg::*;

	localparam int QDEPTH = DEPTH_DEF;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd_item  = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_item_t res_item;

	cmd_item_t cmd_backlog[$];
	res_item_t pending_results[$];

	logic [TIME_W-1:0] shadow_due[QDEPTH];
	logic [ID_W-1:0]   shadow_id[QDEPTH];
	int                shadow_count = 0;
	bit                shadow_open  = 1'b1;

	int errors     = 0;
	int burst_left = 0;
	int gap_left   = 0;
	int sink_left  = 0;

	sorted_timer_event_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Works out the results of one accepted command and updates the shadow queue.
	task automatic apply_timer_cmd(input cmd_item_t it);
		res_item_t r;
		int pos;
		int n;
		r = '0;
		r.last = 1'b1;
		case (it.cmd)
			CMD_ADD: begin
				if (!shadow_open) begin
					r.kind = K_REF_STOP;
				end else if (shadow_count >= QDEPTH) begin
					r.kind = K_REF_FULL;
				end else begin
					pos = 0;
					while (pos < shadow_count && shadow_due[pos] <= it.due_time)
						pos++;
					for (int i = shadow_count; i > pos; i--) begin
						shadow_due[i] = shadow_due[i-1];
						shadow_id[i]  = shadow_id[i-1];
					end
					shadow_due[pos] = it.due_time;
					shadow_id[pos]  = it.event_id;
					shadow_count++;
					r.kind = K_ADDED;
				end
				r.accepting = shadow_open;
				r.occupancy = OCC_W'(shadow_count);
				pending_results.push_back(r);
			end
			CMD_TICK: begin
				n = 0;
				if (shadow_open)
					while (n < shadow_count && shadow_due[n] <= it.now_time)
						n++;
				r.accepting = shadow_open;
				if (n == 0) begin
					r.kind      = K_NONE_DUE;
					r.occupancy = OCC_W'(shadow_count);
					pending_results.push_back(r);
				end else begin
					for (int i = 0; i < n; i++) begin
						r.kind      = K_FIRED;
						r.fired_id  = shadow_id[i];
						r.fired_due = shadow_due[i];
						r.last      = (i == n - 1);
						r.occupancy = OCC_W'(shadow_count - 1 - i);
						pending_results.push_back(r);
					end
					for (int i = n; i < shadow_count; i++) begin
						shadow_due[i-n] = shadow_due[i];
						shadow_id[i-n]  = shadow_id[i];
					end
					shadow_count -= n;
				end
			end
			CMD_STOP: begin
				shadow_open = 1'b0;
				r.kind      = K_STOPPED;
				r.accepting = 1'b0;
				r.occupancy = OCC_W'(shadow_count);
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TIME_W-1:0];
	endfunction

	function automatic logic [ID_W-1:0] rand_id();
		return ID_W'($urandom_range(0, 16'hFFFF));
	endfunction

	task automatic queue_cmd(input cmd_t c, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] due, input logic [TIME_W-1:0] now);
		cmd_item_t it;
		it.cmd      = c;
		it.event_id = id;
		it.due_time = due;
		it.now_time = now;
		cmd_backlog.push_back(it);
	endtask

	always @(posedge clk) begin : drive
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready)
				apply_timer_cmd(cmd_item);
			if (!cmd_valid || cmd_ready) begin
				if (gap_left > 0 || cmd_backlog.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					cmd_valid <= 1'b0;
				end else begin
					cmd_item  <= cmd_backlog.pop_front();
					cmd_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : sink
		if (!arst_n) begin
			res_ready <= 1'b0;
			sink_left = 0;
		end else if (sink_left > 0) begin
			sink_left--;
		end else if (res_ready) begin
			if ($urandom_range(0, 3) == 0) begin
				sink_left = $urandom_range(60, 200);
			end else begin
				res_ready <= 1'b0;
				sink_left = $urandom_range(0, 5);
			end
		end else begin
			res_ready <= 1'b1;
			sink_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 20);
		end
	end

	always @(posedge clk) begin : watch
		res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d id %0h", res_item.kind, res_item.fired_id);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (res_item.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, res_item.kind);
					errors++;
				end
				if (res_item.fired_id !== want.fired_id) begin
					$error("fired_id: expected %0h, got %0h", want.fired_id, res_item.fired_id);
					errors++;
				end
				if (res_item.fired_due !== want.fired_due) begin
					$error("fired_due: expected %0h, got %0h", want.fired_due,
						res_item.fired_due);
					errors++;
				end
				if (res_item.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, res_item.last);
					errors++;
				end
				if (res_item.accepting !== want.accepting) begin
					$error("accepting: expected %0b, got %0b", want.accepting,
						res_item.accepting);
					errors++;
				end
				if (res_item.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						res_item.occupancy);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [TIME_W-1:0] base;
		logic [TIME_W-1:0] tie_due;
		int n;
		int k;
		int pick;

		// empty tick, extremes, equal due times, unused code
		queue_cmd(CMD_TICK, '0, '0, '0);
		queue_cmd(CMD_ADD, 16'h0000, '0, '0);
		queue_cmd(CMD_ADD, 16'hFFFF, '1, '0);
		queue_cmd(CMD_ADD, 16'h0001, '0, '1);
		queue_cmd(cmd_t'(2'd3), 16'hFFFF, '1, '0);
		queue_cmd(CMD_TICK, '0, '0, '1);
		// fill with falling due times (every insert at the front), then one too many
		for (int i = 0; i < QDEPTH; i++)
			queue_cmd(CMD_ADD, ID_W'(16'h0100 + i), TIME_W'(100 + QDEPTH - 1 - i), '0);
		queue_cmd(CMD_ADD, 16'hFFFF, '0, '0);
		queue_cmd(CMD_TICK, rand_id(), rand_time(), '1);

		base = '0;
		n = 0;
		while (n < 410) begin
			pick = $urandom_range(0, 19);
			if (pick < 11) begin
				k = $urandom_range(1, 8);
				repeat (k)
					queue_cmd(CMD_ADD, rand_id(), base + $urandom_range(0, 30), rand_time());
				n += k;
				k = $urandom_range(1, 3);
				repeat (k) begin
					base += $urandom_range(0, 15);
					queue_cmd(CMD_TICK, rand_id(), rand_time(), base);
				end
				n += k;
			end else if (pick < 13) begin
				k = $urandom_range(QDEPTH, QDEPTH + 3);
				repeat (k)
					queue_cmd(CMD_ADD, rand_id(), base + $urandom_range(0, 3), rand_time());
				base += 40;
				queue_cmd(CMD_TICK, rand_id(), rand_time(), base);
				n += k + 1;
			end else if (pick < 15) begin
				k = $urandom_range(2, 6);
				tie_due = base + $urandom_range(1, 10);
				repeat (k)
					queue_cmd(CMD_ADD, rand_id(), tie_due, rand_time());
				base += 12;
				queue_cmd(CMD_TICK, rand_id(), rand_time(), base);
				n += k + 1;
			end else if (pick < 17) begin
				k = $urandom_range(1, 3);
				repeat (k)
					queue_cmd(CMD_ADD, rand_id(), rand_time(), rand_time());
				queue_cmd(CMD_TICK, rand_id(), rand_time(), rand_time());
				queue_cmd(CMD_TICK, rand_id(), rand_time(), '1);
				n += k + 2;
			end else if (pick < 19) begin
				queue_cmd(CMD_TICK, rand_id(), rand_time(),
					($urandom_range(0, 1) == 0) ? '0 : base);
				n += 1;
			end else begin
				queue_cmd(cmd_t'(2'd3), rand_id(), rand_time(), rand_time());
			end
		end

		// stop with events still queued, then a refused add, an idle tick and a second stop
		queue_cmd(CMD_ADD, 16'hA5A5, base + 100, '0);
		queue_cmd(CMD_ADD, 16'h5A5A, base + 100, '0);
		queue_cmd(CMD_STOP, '0, '0, '0);
		queue_cmd(CMD_ADD, 16'h1234, '0, '0);
		queue_cmd(CMD_TICK, '0, '0, '1);
		queue_cmd(CMD_STOP, '0, '0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || cmd_valid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sorted_timer_event_queue.f =====
rtl/core/steq_pkg.sv
rtl/core/sorted_timer_event_queue.sv
tb/sorted_timer_event_queue_tb.sv
